// File: src/tsf_pkg.sv
// Shared types, register codes and constants for the touch sample filter.
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

    localparam logic [11:0] FULL_SCALE    = 12'hFFF;
    localparam logic [11:0] THRESHOLD_RST = 12'd400;
    localparam logic [11:0] WIDTH_RST     = 12'd320;
    localparam logic [11:0] HEIGHT_RST    = 12'd480;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_ROTATION  = 2'd1,
        REG_WIDTH     = 2'd2,
        REG_HEIGHT    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ROT_SWAP_FLIP_X = 2'd0,
        ROT_NONE        = 2'd1,
        ROT_SWAP_FLIP_Y = 2'd2,
        ROT_FLIP_BOTH   = 2'd3
    } t_rot;

    localparam t_rot ROTATION_RST = ROT_FLIP_BOTH;

    typedef struct packed {
        logic [11:0] threshold;
        t_rot        rotation;
        logic [11:0] width;
        logic [11:0] height;
        logic        clear_marks;
    } t_cfg;

    typedef struct packed {
        logic [11:0] press_one;
        logic [11:0] press_two;
        logic [11:0] x_first;
        logic [11:0] x_second;
        logic [11:0] x_third;
        logic [11:0] y_first;
        logic [11:0] y_second;
        logic [11:0] y_third;
    } t_in_item;

    typedef struct packed {
        logic [12:0] pressure;
        logic        touched;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic [11:0] low_x;
        logic [11:0] high_x;
        logic [11:0] low_y;
        logic [11:0] high_y;
    } t_out_item;

    typedef struct packed {
        logic [11:0] pos;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [11:0] size;
    } t_scale_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scale_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_XSTART,
        ST_XWAIT,
        ST_YSTART,
        ST_YWAIT,
        ST_FINISH
    } t_seq_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_LOAD,
        SC_DIV,
        SC_DONE
    } t_scale_state;

endpackage

`default_nettype wire

// File: src/tsf_if.sv
// Valid/ready channel interfaces for measurement sets and filtered results.
`timescale 1ns / 1ps
`default_nettype none

interface tsf_in_if;
    logic               valid;
    logic               ready;
    tsf_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsf_out_if;
    logic               valid;
    logic               ready;
    tsf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/tsf_apb_regs.sv
// APB configuration registers of the touch sample filter.
`timescale 1ns / 1ps
`default_nettype none

module tsf_apb_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output tsf_pkg::t_cfg      o_cfg
);

    logic [11:0]   r_threshold;
    tsf_pkg::t_rot r_rotation;
    logic [11:0]   r_width;
    logic [11:0]   r_height;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tsf_pkg::THRESHOLD_RST;
            r_rotation  <= tsf_pkg::ROTATION_RST;
            r_width     <= tsf_pkg::WIDTH_RST;
            r_height    <= tsf_pkg::HEIGHT_RST;
        end else if (w_wr) begin
            case (tsf_pkg::t_reg_idx'(paddr[3:2]))
                tsf_pkg::REG_THRESHOLD: r_threshold <= pwdata[11:0];
                tsf_pkg::REG_ROTATION:  r_rotation  <= tsf_pkg::t_rot'(pwdata[1:0]);
                tsf_pkg::REG_WIDTH:     r_width     <= pwdata[11:0];
                tsf_pkg::REG_HEIGHT:    r_height    <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (tsf_pkg::t_reg_idx'(paddr[3:2]))
            tsf_pkg::REG_THRESHOLD: prdata = {20'b0, r_threshold};
            tsf_pkg::REG_ROTATION:  prdata = {30'b0, r_rotation};
            tsf_pkg::REG_WIDTH:     prdata = {20'b0, r_width};
            tsf_pkg::REG_HEIGHT:    prdata = {20'b0, r_height};
            default:                prdata = 32'b0;
        endcase
    end

    // Any rotation write restarts calibration.
    always_comb begin
        o_cfg.threshold   = r_threshold;
        o_cfg.rotation    = r_rotation;
        o_cfg.width       = r_width;
        o_cfg.height      = r_height;
        o_cfg.clear_marks = w_wr &&
                            (tsf_pkg::t_reg_idx'(paddr[3:2]) == tsf_pkg::REG_ROTATION);
    end

endmodule

`default_nettype wire

// File: src/tsf_pair_mean.sv
// Best-two-of-three filter: mean of the closest pair of three readings.
`timescale 1ns / 1ps
`default_nettype none

module tsf_pair_mean (
    input  wire logic [11:0] i_a,
    input  wire logic [11:0] i_b,
    input  wire logic [11:0] i_c,
    output logic      [11:0] o_mean
);

    logic [11:0] w_dab;
    logic [11:0] w_dac;
    logic [11:0] w_dbc;
    logic [12:0] w_sum;

    assign w_dab = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
    assign w_dac = (i_a > i_c) ? (i_a - i_c) : (i_c - i_a);
    assign w_dbc = (i_b > i_c) ? (i_b - i_c) : (i_c - i_b);

    // Ties go to the earlier pair: (a,b), then (a,c), then (b,c).
    always_comb begin
        if (w_dab <= w_dac && w_dab <= w_dbc) begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end else if (w_dac <= w_dab && w_dac <= w_dbc) begin
            w_sum = {1'b0, i_a} + {1'b0, i_c};
        end else begin
            w_sum = {1'b0, i_b} + {1'b0, i_c};
        end
    end

    assign o_mean = w_sum[12:1];

endmodule

`default_nettype wire

// File: src/tsf_scale_unit.sv
// Shared scaling unit: (pos - lo) * size / (hi - lo) with a restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module tsf_scale_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire tsf_pkg::t_scale_req i_req,
    output tsf_pkg::t_scale_stat    o_stat,
    output logic [11:0]             o_quot
);

    tsf_pkg::t_scale_state r_state;
    tsf_pkg::t_scale_state n_state;

    logic [11:0] r_diff;
    logic [11:0] r_den;
    logic [11:0] r_size;
    logic        r_zero;
    logic [23:0] r_num;
    logic [11:0] r_rem;
    logic [11:0] r_low;
    logic [11:0] r_quot;
    logic [3:0]  r_cnt;

    logic        w_sat;
    logic [12:0] w_trial;
    logic        w_qbit;
    logic [11:0] w_rem_next;

    // A quotient of 4096 or more saturates; below that it fits 12 bits.
    assign w_sat      = r_num >= {r_den, 12'b0};
    assign w_trial    = {r_rem, r_low[11]};
    assign w_qbit     = w_trial >= {1'b0, r_den};
    assign w_rem_next = w_qbit ? 12'(w_trial - {1'b0, r_den}) : w_trial[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsf_pkg::SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            tsf_pkg::SC_IDLE: n_state = i_start ? tsf_pkg::SC_MUL : tsf_pkg::SC_IDLE;
            tsf_pkg::SC_MUL:  n_state = tsf_pkg::SC_LOAD;
            tsf_pkg::SC_LOAD: n_state = (r_zero || w_sat) ? tsf_pkg::SC_DONE : tsf_pkg::SC_DIV;
            tsf_pkg::SC_DIV:  n_state = (r_cnt == 4'd0) ? tsf_pkg::SC_DONE : tsf_pkg::SC_DIV;
            tsf_pkg::SC_DONE: n_state = tsf_pkg::SC_IDLE;
            default:          n_state = tsf_pkg::SC_IDLE;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state != tsf_pkg::SC_IDLE);
        o_stat.done = (r_state == tsf_pkg::SC_DONE);
        o_quot      = r_quot;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tsf_pkg::SC_IDLE: begin
                if (i_start) begin
                    r_diff <= i_req.pos - i_req.lo;
                    r_den  <= i_req.hi - i_req.lo;
                    r_size <= i_req.size;
                    r_zero <= (i_req.hi <= i_req.lo) || (i_req.pos < i_req.lo);
                end
            end
            tsf_pkg::SC_MUL: begin
                r_num <= {12'b0, r_diff} * {12'b0, r_size};
            end
            tsf_pkg::SC_LOAD: begin
                r_rem <= r_num[23:12];
                r_low <= r_num[11:0];
                r_cnt <= 4'd11;
                if (r_zero) begin
                    r_quot <= 12'd0;
                end else if (w_sat) begin
                    r_quot <= tsf_pkg::FULL_SCALE;
                end else begin
                    r_quot <= 12'd0;
                end
            end
            tsf_pkg::SC_DIV: begin
                r_rem  <= w_rem_next;
                r_low  <= {r_low[10:0], 1'b0};
                r_quot <= {r_quot[10:0], w_qbit};
                r_cnt  <= r_cnt - 4'd1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: src/touch_sample_filter.sv
// Top level of the touch sample filter: sequencer, held position and calibration marks.
//
//   Channel  Direction  Handshake        Carries
//   i_in     in         valid / ready    one measurement set (pressure, 3 X, 3 Y)
//   o_out    out        valid / ready    pressure, touch flag, position, screen, marks
//   APB      in         psel / penable   threshold, rotation, screen width and height
//
// A result is offered after its item's transfer: the CALC state filters and rotates,
// the shared scaling unit runs twice (X, then Y) through start, multiply, load, a
// 12-step restoring division and done, and FINISH loads the output register. A run with
// empty marks, a position below the low mark or a saturated quotient skips the division.
// Input is taken only while the sequencer is idle, i.e. once the last result is loaded;
// an unread result in the output register stalls the next one. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    tsf_in_if.sink           i_in,
    tsf_out_if.source        o_out
);

    tsf_pkg::t_cfg         w_cfg;
    tsf_pkg::t_seq_state   r_state;
    tsf_pkg::t_seq_state   n_state;
    tsf_pkg::t_in_item     r_item;
    tsf_pkg::t_out_item    r_out;
    logic                  r_out_valid;

    logic [11:0] r_last_x;
    logic [11:0] r_last_y;
    logic [11:0] r_low_x;
    logic [11:0] r_high_x;
    logic [11:0] r_low_y;
    logic [11:0] r_high_y;
    logic [12:0] r_press;
    logic        r_touch;
    logic [11:0] r_scr_x;
    logic [11:0] r_scr_y;

    logic [12:0] w_press;
    logic        w_touch;
    logic [11:0] w_fx;
    logic [11:0] w_fy;
    logic [11:0] w_rot_x;
    logic [11:0] w_rot_y;
    logic        w_start;
    logic        w_load_out;

    tsf_pkg::t_scale_req  w_req;
    tsf_pkg::t_scale_stat w_stat;
    logic [11:0]          w_quot;

    tsf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tsf_pair_mean u_mean_x (
        .i_a    (r_item.x_first),
        .i_b    (r_item.x_second),
        .i_c    (r_item.x_third),
        .o_mean (w_fx)
    );

    tsf_pair_mean u_mean_y (
        .i_a    (r_item.y_first),
        .i_b    (r_item.y_second),
        .i_c    (r_item.y_third),
        .o_mean (w_fy)
    );

    tsf_scale_unit u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_stat  (w_stat),
        .o_quot  (w_quot)
    );

    assign w_press = {1'b0, tsf_pkg::FULL_SCALE - r_item.press_two} + {1'b0, r_item.press_one};
    assign w_touch = w_press >= {1'b0, w_cfg.threshold};

    always_comb begin
        case (w_cfg.rotation)
            tsf_pkg::ROT_SWAP_FLIP_X: begin
                w_rot_x = tsf_pkg::FULL_SCALE - w_fy;
                w_rot_y = w_fx;
            end
            tsf_pkg::ROT_NONE: begin
                w_rot_x = w_fx;
                w_rot_y = w_fy;
            end
            tsf_pkg::ROT_SWAP_FLIP_Y: begin
                w_rot_x = w_fy;
                w_rot_y = tsf_pkg::FULL_SCALE - w_fx;
            end
            default: begin
                w_rot_x = tsf_pkg::FULL_SCALE - w_fx;
                w_rot_y = tsf_pkg::FULL_SCALE - w_fy;
            end
        endcase
    end

    // The sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            tsf_pkg::ST_IDLE:   n_state = i_in.valid ? tsf_pkg::ST_CALC : tsf_pkg::ST_IDLE;
            tsf_pkg::ST_CALC:   n_state = tsf_pkg::ST_XSTART;
            tsf_pkg::ST_XSTART: n_state = tsf_pkg::ST_XWAIT;
            tsf_pkg::ST_XWAIT:  n_state = w_stat.done ? tsf_pkg::ST_YSTART : tsf_pkg::ST_XWAIT;
            tsf_pkg::ST_YSTART: n_state = tsf_pkg::ST_YWAIT;
            tsf_pkg::ST_YWAIT:  n_state = w_stat.done ? tsf_pkg::ST_FINISH : tsf_pkg::ST_YWAIT;
            tsf_pkg::ST_FINISH: n_state = w_load_out ? tsf_pkg::ST_IDLE : tsf_pkg::ST_FINISH;
            default:            n_state = tsf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == tsf_pkg::ST_IDLE);
        w_start    = (r_state == tsf_pkg::ST_XSTART) || (r_state == tsf_pkg::ST_YSTART);
        // The result register is free once its previous result has been transferred.
        w_load_out = (r_state == tsf_pkg::ST_FINISH) && (!r_out_valid || o_out.ready);
        if (r_state == tsf_pkg::ST_YSTART) begin
            w_req.pos  = r_last_y;
            w_req.lo   = r_low_y;
            w_req.hi   = r_high_y;
            w_req.size = w_cfg.height;
        end else begin
            w_req.pos  = r_last_x;
            w_req.lo   = r_low_x;
            w_req.hi   = r_high_x;
            w_req.size = w_cfg.width;
        end
    end

    // Held position and calibration marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= 12'd0;
            r_last_y <= 12'd0;
            r_low_x  <= tsf_pkg::FULL_SCALE;
            r_high_x <= 12'd0;
            r_low_y  <= tsf_pkg::FULL_SCALE;
            r_high_y <= 12'd0;
        end else if (w_cfg.clear_marks) begin
            r_low_x  <= tsf_pkg::FULL_SCALE;
            r_high_x <= 12'd0;
            r_low_y  <= tsf_pkg::FULL_SCALE;
            r_high_y <= 12'd0;
        end else if (r_state == tsf_pkg::ST_CALC && w_touch) begin
            r_last_x <= w_rot_x;
            r_last_y <= w_rot_y;
            if (w_rot_x < r_low_x)  r_low_x  <= w_rot_x;
            if (w_rot_x > r_high_x) r_high_x <= w_rot_x;
            if (w_rot_y < r_low_y)  r_low_y  <= w_rot_y;
            if (w_rot_y > r_high_y) r_high_y <= w_rot_y;
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tsf_pkg::ST_IDLE: begin
                if (i_in.valid) r_item <= i_in.data;
            end
            tsf_pkg::ST_CALC: begin
                r_press <= w_touch ? w_press : 13'd0;
                r_touch <= w_touch;
            end
            tsf_pkg::ST_XWAIT: begin
                if (w_stat.done) r_scr_x <= w_quot;
            end
            tsf_pkg::ST_YWAIT: begin
                if (w_stat.done) r_scr_y <= w_quot;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.pressure <= r_press;
            r_out.touched  <= r_touch;
            r_out.pos_x    <= r_last_x;
            r_out.pos_y    <= r_last_y;
            r_out.screen_x <= r_scr_x;
            r_out.screen_y <= r_scr_y;
            r_out.low_x    <= r_low_x;
            r_out.high_x   <= r_high_x;
            r_out.low_y    <= r_low_y;
            r_out.high_y   <= r_high_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_touch_within_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.touched) |->
        (o_out.data.low_x <= o_out.data.pos_x && o_out.data.pos_x <= o_out.data.high_x &&
         o_out.data.low_y <= o_out.data.pos_y && o_out.data.pos_y <= o_out.data.high_y))
        else $error("touched result lies outside its calibration marks");

    a_no_touch_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.touched) |-> (o_out.data.pressure == 13'd0))
        else $error("untouched result carries a nonzero pressure");

    a_scale_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_stat.busy)
        else $error("scaling unit started while busy");

    a_result_after_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (r_state == tsf_pkg::ST_FINISH && $past(r_state) != tsf_pkg::ST_IDLE))
        else $error("result loaded outside the finishing step");
`endif

endmodule

`default_nettype wire
